// ===== design/mcp0_pkg.sv =====
// types and constants shared by the composition data page 0 parser
`default_nettype none

package mcp0_pkg;

  localparam int MAX_RECS = 3;

  typedef enum logic [2:0] {
    KIND_FEATURES = 3'd0,
    KIND_SIG      = 3'd1,
    KIND_VENDOR   = 3'd2,
    KIND_ELEM_END = 3'd3,
    KIND_PAGE_END = 3'd4
  } rec_kind_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LOC    = 3'd1,
    PH_COUNTS = 3'd2,
    PH_SIG    = 3'd3,
    PH_VENDOR = 3'd4
  } phase_t;

  localparam logic [3:0]  FEAT_LO_POS = 4'd8;
  localparam logic [3:0]  FEAT_HI_POS = 4'd9;

  localparam logic [15:0] CFG_SRV_ID  = 16'h0000;
  localparam logic [15:0] CFG_CLI_ID  = 16'h0001;
  localparam logic [15:0] ONOFF_ID    = 16'h1000;
  localparam logic [15:0] LIGHTNESS_ID = 16'h1300;
  localparam logic [15:0] CTL_ID      = 16'h1303;
  localparam logic [15:0] SENSOR_ID   = 16'h1100;
  localparam logic [15:0] LC_ID       = 16'h130f;

  typedef struct packed {
    rec_kind_t   kind;
    logic [15:0] primary;
    logic [15:0] secondary;
    logic [7:0]  index;
    logic [7:0]  sig_cnt;
    logic [7:0]  ven_cnt;
    logic [4:0]  mask;
    logic [7:0]  elem_cnt;
    logic        trunc;
    logic        last;
  } rec_t;

  typedef struct packed {
    logic [1:0]                n;
    rec_t [MAX_RECS-1:0]       recs;
  } push_t;

endpackage

`default_nettype wire

// ===== design/mcp0_parse.sv =====
// byte parser: running page state and up to three records per byte
`default_nettype none

module mcp0_parse
  import mcp0_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_data,
  input  wire logic       byte_last,
  input  wire logic [4:0] init_mask,
  output push_t           push
);

  phase_t      phase_r, phase_nxt, phase_c;
  logic [3:0]  pos_r, pos_nxt, pos_c;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] company_r, company_nxt;
  logic [7:0]  sig_rem_r, sig_rem_nxt;
  logic [7:0]  ven_rem_r, ven_rem_nxt;
  logic [7:0]  ven_tot_r, ven_tot_nxt;
  logic [7:0]  kept_r, kept_nxt;
  logic [7:0]  elem_r, elem_nxt, elem_c;
  logic [4:0]  mask_r, mask_nxt, mask_c;
  logic        started_r, started_nxt;

  logic        emit_main;
  rec_kind_t   main_kind;
  logic [15:0] main_prim;
  logic [15:0] main_sec;
  logic        end_elem;
  logic        trunc;
  logic [15:0] word;

  assign word = {byte_data, low_r};

  // next state
  always_comb begin
    phase_c = started_r ? phase_r : PH_HEADER;
    pos_c   = started_r ? pos_r : 4'd0;
    elem_c  = started_r ? elem_r : 8'd0;
    mask_c  = started_r ? mask_r : init_mask;

    phase_nxt   = phase_c;
    pos_nxt     = pos_c;
    low_nxt     = low_r;
    company_nxt = company_r;
    sig_rem_nxt = sig_rem_r;
    ven_rem_nxt = ven_rem_r;
    ven_tot_nxt = ven_tot_r;
    kept_nxt    = kept_r;
    mask_nxt    = mask_c;
    emit_main   = 1'b0;
    main_kind   = KIND_FEATURES;
    main_prim   = 16'd0;
    main_sec    = 16'd0;
    end_elem    = 1'b0;

    case (phase_c)
      PH_HEADER: begin
        if (pos_c == FEAT_LO_POS) begin
          low_nxt = byte_data;
          pos_nxt = pos_c + 4'd1;
        end else if (pos_c == FEAT_HI_POS) begin
          emit_main = 1'b1;
          main_kind = KIND_FEATURES;
          main_prim = word;
          phase_nxt = PH_LOC;
          pos_nxt   = 4'd0;
        end else begin
          pos_nxt = pos_c + 4'd1;
        end
      end
      PH_LOC: begin
        if (pos_c == 4'd0) begin
          pos_nxt = 4'd1;
        end else begin
          phase_nxt = PH_COUNTS;
          pos_nxt   = 4'd0;
        end
      end
      PH_COUNTS: begin
        if (pos_c == 4'd0) begin
          sig_rem_nxt = byte_data;
          kept_nxt    = 8'd0;
          pos_nxt     = 4'd1;
        end else begin
          ven_rem_nxt = byte_data;
          ven_tot_nxt = byte_data;
          pos_nxt     = 4'd0;
          if (sig_rem_r != 8'd0) begin
            phase_nxt = PH_SIG;
          end else if (byte_data != 8'd0) begin
            phase_nxt = PH_VENDOR;
          end else begin
            end_elem = 1'b1;
          end
        end
      end
      PH_SIG: begin
        if (pos_c == 4'd0) begin
          low_nxt = byte_data;
          pos_nxt = 4'd1;
        end else begin
          pos_nxt = 4'd0;
          if (word == ONOFF_ID) begin
            mask_nxt = mask_c | 5'b00001;
          end else if (word == LIGHTNESS_ID) begin
            mask_nxt = mask_c | 5'b00010;
          end else if (word == CTL_ID) begin
            mask_nxt = mask_c | 5'b00100;
          end else if (word == SENSOR_ID) begin
            mask_nxt = mask_c | 5'b01000;
          end else if (word == LC_ID) begin
            mask_nxt = mask_c | 5'b10000;
          end
          if (word != CFG_SRV_ID && word != CFG_CLI_ID) begin
            kept_nxt  = kept_r + 8'd1;
            emit_main = 1'b1;
            main_kind = KIND_SIG;
            main_prim = word;
          end
          sig_rem_nxt = sig_rem_r - 8'd1;
          if (sig_rem_nxt == 8'd0) begin
            if (ven_rem_r != 8'd0) begin
              phase_nxt = PH_VENDOR;
            end else begin
              end_elem = 1'b1;
            end
          end
        end
      end
      default: begin
        if (pos_c == 4'd0 || pos_c == 4'd2) begin
          low_nxt = byte_data;
          pos_nxt = pos_c + 4'd1;
        end else if (pos_c == 4'd1) begin
          company_nxt = word;
          pos_nxt     = 4'd2;
        end else begin
          pos_nxt     = 4'd0;
          emit_main   = 1'b1;
          main_kind   = KIND_VENDOR;
          main_prim   = company_r;
          main_sec    = word;
          ven_rem_nxt = ven_rem_r - 8'd1;
          if (ven_rem_nxt == 8'd0) begin
            end_elem = 1'b1;
          end
        end
      end
    endcase

    elem_nxt = elem_c;
    if (end_elem) begin
      phase_nxt = PH_LOC;
      pos_nxt   = 4'd0;
      if (elem_c != 8'hff) begin
        elem_nxt = elem_c + 8'd1;
      end
    end

    trunc = !(phase_nxt == PH_LOC && pos_nxt == 4'd0);

    started_nxt = 1'b1;
    if (byte_last) begin
      started_nxt = 1'b0;
      phase_nxt   = PH_HEADER;
      pos_nxt     = 4'd0;
    end
  end

  // record list
  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    push.recs = '0;

    if (emit_main) begin
      push.recs[k].kind      = main_kind;
      push.recs[k].primary   = main_prim;
      push.recs[k].secondary = main_sec;
      push.recs[k].index     = (main_kind == KIND_FEATURES) ? 8'd0 : elem_c;
      push.recs[k].mask      = mask_nxt;
      k = k + 2'd1;
    end
    if (end_elem) begin
      push.recs[k].kind    = KIND_ELEM_END;
      push.recs[k].index   = elem_c;
      push.recs[k].sig_cnt = kept_nxt;
      push.recs[k].ven_cnt = ven_tot_nxt;
      push.recs[k].mask    = mask_nxt;
      k = k + 2'd1;
    end
    if (byte_last) begin
      push.recs[k].kind     = KIND_PAGE_END;
      push.recs[k].elem_cnt = elem_nxt;
      push.recs[k].trunc    = trunc;
      push.recs[k].mask     = mask_nxt;
      k = k + 2'd1;
    end
    if (k != 2'd0) begin
      push.recs[k - 2'd1].last = 1'b1;
    end
    push.n = byte_valid ? k : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      pos_r     <= 4'd0;
      low_r     <= 8'd0;
      company_r <= 16'd0;
      sig_rem_r <= 8'd0;
      ven_rem_r <= 8'd0;
      ven_tot_r <= 8'd0;
      kept_r    <= 8'd0;
      elem_r    <= 8'd0;
      mask_r    <= 5'd0;
      started_r <= 1'b0;
    end else if (byte_valid) begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      low_r     <= low_nxt;
      company_r <= company_nxt;
      sig_rem_r <= sig_rem_nxt;
      ven_rem_r <= ven_rem_nxt;
      ven_tot_r <= ven_tot_nxt;
      kept_r    <= kept_nxt;
      elem_r    <= elem_nxt;
      mask_r    <= mask_nxt;
      started_r <= started_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mcp0_rec_fifo.sv =====
// result queue: takes up to three records per cycle, hands out one
`default_nettype none

module mcp0_rec_fifo
  import mcp0_pkg::*;
#(
  parameter int Depth = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire push_t                      push,
  input  wire logic                       pop,
  output rec_t                            head_rec,
  output logic [$clog2(Depth+1)-1:0]      cnt
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem_r [Depth];
  logic [PtrW-1:0] head_r, head_nxt;
  logic [PtrW-1:0] tail_r, tail_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [PtrW-1:0] widx [MAX_RECS];

  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] p,
                                                input logic [1:0] k);
    logic [PtrW:0] s;
    s = {1'b0, p} + (PtrW+1)'(k);
    if (s >= (PtrW+1)'(Depth)) begin
      s = s - (PtrW+1)'(Depth);
    end
    return s[PtrW-1:0];
  endfunction

  always_comb begin
    for (int i = 0; i < MAX_RECS; i++) begin
      widx[i] = ptr_add(tail_r, 2'(i));
    end
    tail_nxt = ptr_add(tail_r, push.n);
    head_nxt = pop ? ptr_add(head_r, 2'd1) : head_r;
    cnt_nxt  = cnt_r + CntW'(push.n) - CntW'(pop);
  end

  assign head_rec = mem_r[head_r];
  assign cnt      = cnt_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RECS; i++) begin
      if (2'(i) < push.n) begin
        mem_r[widx[i]] <= push.recs[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/mesh_composition_page0_parser.sv =====
// top level of the composition data page 0 parser
// path: an accepted byte passes the staging register, then its records the record queue
// throughput: one byte per cycle while each byte yields at most one record and
//   out_stall is low; a three-record byte drains through the one-record output port
// reset: synchronous active-low rst_n clears the page state, queue and mask register
`default_nettype none

module mesh_composition_page0_parser
  import mcp0_pkg::*;
#(
  parameter int FifoDepth = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_record_kind,
  output logic [15:0]      out_primary_value,
  output logic [15:0]      out_secondary_value,
  output logic [7:0]       out_element_index,
  output logic [7:0]       out_sig_model_count,
  output logic [7:0]       out_vendor_model_count,
  output logic [4:0]       out_function_mask,
  output logic [7:0]       out_element_count,
  output logic             out_truncated,
  output logic             out_last_result,
  input  wire logic        cfg_wr_en,
  input  wire logic [4:0]  cfg_wr_data
);

  localparam int CntW = $clog2(FifoDepth + 1);

  logic [4:0]      init_mask_r;
  logic            stage_valid_r;
  logic [7:0]      stage_byte_r;
  logic            stage_last_r;
  push_t           push;
  rec_t            head_rec;
  logic [CntW-1:0] fifo_cnt;
  logic            in_take;

  // room for the staged byte and one more
  assign in_stall = (fifo_cnt > CntW'(FifoDepth - 2 * MAX_RECS));
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_mask_r   <= 5'd0;
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= in_take;
      if (cfg_wr_en) begin
        init_mask_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_byte_r <= in_data_byte;
      stage_last_r <= in_last_byte;
    end
  end

  mcp0_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (stage_valid_r),
    .byte_data  (stage_byte_r),
    .byte_last  (stage_last_r),
    .init_mask  (init_mask_r),
    .push       (push)
  );

  mcp0_rec_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (out_valid && !out_stall),
    .head_rec (head_rec),
    .cnt      (fifo_cnt)
  );

  assign out_valid              = (fifo_cnt != '0);
  assign out_record_kind        = head_rec.kind;
  assign out_primary_value      = head_rec.primary;
  assign out_secondary_value    = head_rec.secondary;
  assign out_element_index      = head_rec.index;
  assign out_sig_model_count    = head_rec.sig_cnt;
  assign out_vendor_model_count = head_rec.ven_cnt;
  assign out_function_mask      = head_rec.mask;
  assign out_element_count      = head_rec.elem_cnt;
  assign out_truncated          = head_rec.trunc;
  assign out_last_result        = head_rec.last;

endmodule

`default_nettype wire

// ===== design/mcp0_chk.sv =====
// port checker for the composition data page 0 parser, bound to the top level
`default_nettype none

module mcp0_chk
  import mcp0_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_record_kind,
  input wire logic [15:0] out_primary_value,
  input wire logic [15:0] out_secondary_value,
  input wire logic [7:0]  out_element_index,
  input wire logic        out_truncated,
  input wire logic        out_last_result
);

  // no transaction offered right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_record_kind)
      && $stable(out_primary_value) && $stable(out_last_result))
    else $error("stalled output transaction changed");

  // page end closes the byte's record list
  a_page_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_PAGE_END |-> out_last_result
      && out_primary_value == 16'd0 && out_element_index == 8'd0)
    else $error("page end record malformed");

  a_elem_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_kind == KIND_ELEM_END |-> out_primary_value == 16'd0
      && out_secondary_value == 16'd0 && !out_truncated)
    else $error("element end record malformed");

endmodule

bind mesh_composition_page0_parser mcp0_chk u_chk (.*);

`default_nettype wire

// ===== tb/mesh_composition_page0_parser_test.sv =====
// testbench for the composition data page 0 parser: directed table and random pages vs predictor
`default_nettype none

module mesh_composition_page0_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mcp0_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         typed;
    rec_t       want;
  } byte_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_record_kind;
  logic [15:0] out_primary_value;
  logic [15:0] out_secondary_value;
  logic [7:0]  out_element_index;
  logic [7:0]  out_sig_model_count;
  logic [7:0]  out_vendor_model_count;
  logic [4:0]  out_function_mask;
  logic [7:0]  out_element_count;
  logic        out_truncated;
  logic        out_last_result;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  mesh_composition_page0_parser DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_data_byte           (in_data_byte),
    .in_last_byte           (in_last_byte),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_record_kind        (out_record_kind),
    .out_primary_value      (out_primary_value),
    .out_secondary_value    (out_secondary_value),
    .out_element_index      (out_element_index),
    .out_sig_model_count    (out_sig_model_count),
    .out_vendor_model_count (out_vendor_model_count),
    .out_function_mask      (out_function_mask),
    .out_element_count      (out_element_count),
    .out_truncated          (out_truncated),
    .out_last_result        (out_last_result),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_wr_data            (cfg_wr_data)
  );

  // page walker state
  phase_t      walk_phase;
  logic [3:0]  walk_pos;
  logic [7:0]  held_lo;
  logic [15:0] held_company;
  logic [7:0]  sig_left;
  logic [7:0]  ven_left;
  logic [7:0]  ven_total;
  logic [7:0]  kept_sig;
  logic [7:0]  elem_ctr;
  logic [4:0]  func_mask;
  logic        in_page;
  logic [4:0]  mask_reg;

  rec_t      expected_records[$];
  byte_row_t byte_stream[$];
  byte_row_t directed_rows[23];
  int        mismatches = 0;
  int        burst_left = 0;
  int        stall_mode = 0;
  int        mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic rec_t make_rec(rec_kind_t k, logic [15:0] prim, logic [15:0] sec,
                                    logic [7:0] idx, logic [7:0] sc, logic [7:0] vc,
                                    logic [7:0] elc, logic tr);
    rec_t r;
    r.kind      = k;
    r.primary   = prim;
    r.secondary = sec;
    r.index     = idx;
    r.sig_cnt   = sc;
    r.ven_cnt   = vc;
    r.mask      = func_mask;
    r.elem_cnt  = elc;
    r.trunc     = tr;
    r.last      = 1'b0;
    return r;
  endfunction

  task automatic close_element(ref rec_t recs[$]);
    recs.push_back(make_rec(KIND_ELEM_END, 16'h0, 16'h0, elem_ctr, kept_sig, ven_total,
                            8'h0, 1'b0));
    if (elem_ctr != 8'hff) elem_ctr++;
    walk_phase = PH_LOC;
    walk_pos   = 4'd0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lastb, ref rec_t recs[$]);
    logic [15:0] word;
    word = {b, held_lo};
    if (!in_page) begin
      in_page    = 1'b1;
      func_mask  = mask_reg;
      elem_ctr   = 8'h0;
      walk_phase = PH_HEADER;
      walk_pos   = 4'd0;
    end
    case (walk_phase)
      PH_HEADER: begin
        if (walk_pos == FEAT_LO_POS) begin
          held_lo = b;
          walk_pos++;
        end else if (walk_pos == FEAT_HI_POS) begin
          recs.push_back(make_rec(KIND_FEATURES, word, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0, 1'b0));
          walk_phase = PH_LOC;
          walk_pos   = 4'd0;
        end else begin
          walk_pos++;
        end
      end
      PH_LOC: begin
        if (walk_pos == 4'd0) begin
          walk_pos = 4'd1;
        end else begin
          walk_phase = PH_COUNTS;
          walk_pos   = 4'd0;
        end
      end
      PH_COUNTS: begin
        if (walk_pos == 4'd0) begin
          sig_left = b;
          kept_sig = 8'h0;
          walk_pos = 4'd1;
        end else begin
          ven_left  = b;
          ven_total = b;
          walk_pos  = 4'd0;
          if (sig_left != 8'h0) walk_phase = PH_SIG;
          else if (ven_left != 8'h0) walk_phase = PH_VENDOR;
          else close_element(recs);
        end
      end
      PH_SIG: begin
        if (walk_pos == 4'd0) begin
          held_lo  = b;
          walk_pos = 4'd1;
        end else begin
          walk_pos = 4'd0;
          case (word)
            ONOFF_ID:     func_mask[0] = 1'b1;
            LIGHTNESS_ID: func_mask[1] = 1'b1;
            CTL_ID:       func_mask[2] = 1'b1;
            SENSOR_ID:    func_mask[3] = 1'b1;
            LC_ID:        func_mask[4] = 1'b1;
            default: ;
          endcase
          if (word != CFG_SRV_ID && word != CFG_CLI_ID) begin
            kept_sig++;
            recs.push_back(make_rec(KIND_SIG, word, 16'h0, elem_ctr, 8'h0, 8'h0, 8'h0, 1'b0));
          end
          sig_left--;
          if (sig_left == 8'h0) begin
            if (ven_left != 8'h0) walk_phase = PH_VENDOR;
            else close_element(recs);
          end
        end
      end
      default: begin
        case (walk_pos)
          4'd0, 4'd2: begin
            held_lo = b;
            walk_pos++;
          end
          4'd1: begin
            held_company = word;
            walk_pos     = 4'd2;
          end
          default: begin
            walk_pos = 4'd0;
            recs.push_back(make_rec(KIND_VENDOR, held_company, word, elem_ctr, 8'h0, 8'h0,
                                    8'h0, 1'b0));
            ven_left--;
            if (ven_left == 8'h0) close_element(recs);
          end
        endcase
      end
    endcase
    if (lastb) begin
      recs.push_back(make_rec(KIND_PAGE_END, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, elem_ctr,
                              !(walk_phase == PH_LOC && walk_pos == 4'd0)));
      in_page    = 1'b0;
      walk_phase = PH_HEADER;
      walk_pos   = 4'd0;
    end
    if (recs.size() > 0) recs[recs.size()-1].last = 1'b1;
  endtask

  task automatic check_record();
    rec_t want;
    if (expected_records.size() == 0) begin
      report_mismatch("record with nothing expected, kind", 16'(out_record_kind), 16'h0);
      return;
    end
    want = expected_records.pop_front();
    if (out_record_kind !== want.kind)
      report_mismatch("kind", 16'(out_record_kind), 16'(want.kind));
    if (out_primary_value !== want.primary)
      report_mismatch("primary", out_primary_value, want.primary);
    if (out_secondary_value !== want.secondary)
      report_mismatch("secondary", out_secondary_value, want.secondary);
    if (out_element_index !== want.index)
      report_mismatch("element index", 16'(out_element_index), 16'(want.index));
    if (out_sig_model_count !== want.sig_cnt)
      report_mismatch("sig count", 16'(out_sig_model_count), 16'(want.sig_cnt));
    if (out_vendor_model_count !== want.ven_cnt)
      report_mismatch("vendor count", 16'(out_vendor_model_count), 16'(want.ven_cnt));
    if (out_function_mask !== want.mask)
      report_mismatch("function mask", 16'(out_function_mask), 16'(want.mask));
    if (out_element_count !== want.elem_cnt)
      report_mismatch("element count", 16'(out_element_count), 16'(want.elem_cnt));
    if (out_truncated !== want.trunc)
      report_mismatch("truncated", 16'(out_truncated), 16'(want.trunc));
    if (out_last_result !== want.last)
      report_mismatch("last result", 16'(out_last_result), 16'(want.last));
  endtask

  // result side: check and stall pattern
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_record();
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 96);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (mode_left % 3 == 0);
    endcase
  end

  task automatic send_stream();
    byte_row_t row;
    rec_t      made[$];
    int        gap;
    while (byte_stream.size() > 0) begin
      row = byte_stream.pop_front();
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid     <= 1'b1;
      in_data_byte <= row.data;
      in_last_byte <= row.last;
      do @(posedge clk); while (in_stall);
      made.delete();
      parse_byte(row.data, row.last, made);
      if (row.typed) expected_records.push_back(row.want);
      else foreach (made[i]) expected_records.push_back(made[i]);
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    while (expected_records.size() > 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mask(input logic [4:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mask_reg    = v;
  endtask

  task automatic add_row(input logic [7:0] d, input logic l);
    byte_row_t r;
    r.data  = d;
    r.last  = l;
    r.typed = 1'b0;
    r.want  = '0;
    byte_stream.push_back(r);
  endtask

  function automatic logic [15:0] pick_sig_id();
    case ($urandom_range(0, 11))
      0: return CFG_SRV_ID;
      1: return CFG_CLI_ID;
      2: return ONOFF_ID;
      3: return LIGHTNESS_ID;
      4: return CTL_ID;
      5: return SENSOR_ID;
      6: return LC_ID;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_random_page();
    logic [7:0]  pg[$];
    logic [15:0] id;
    int          ne;
    int          ns;
    int          nv;
    int          cut_at;
    if ($urandom_range(0, 5) == 0) begin
      // noise
      repeat ($urandom_range(1, 24)) pg.push_back(8'($urandom));
    end else begin
      repeat (10) pg.push_back(8'($urandom));
      ne = $urandom_range(0, 3);
      repeat (ne) begin
        pg.push_back(8'($urandom));
        pg.push_back(8'($urandom));
        ns = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 9) : $urandom_range(0, 3);
        nv = $urandom_range(0, 2);
        pg.push_back(8'(ns));
        pg.push_back(8'(nv));
        repeat (ns) begin
          id = pick_sig_id();
          pg.push_back(id[7:0]);
          pg.push_back(id[15:8]);
        end
        repeat (nv * 4) pg.push_back(8'($urandom));
      end
      if ($urandom_range(0, 4) == 0) begin
        cut_at = $urandom_range(1, pg.size() - 1);
        while (pg.size() > cut_at) void'(pg.pop_back());
      end
    end
    foreach (pg[i]) add_row(pg[i], i == pg.size() - 1);
  endtask

  task automatic add_random_pages(input int n_items);
    int start;
    start = byte_stream.size();
    while (byte_stream.size() - start < n_items) add_random_page();
  endtask

  initial begin
    byte_row_t tail[$];
    int        split;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h0;
    in_last_byte <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 5'h0;
    rst_n        <= 1'b0;
    walk_phase   = PH_HEADER;
    walk_pos     = 4'd0;
    held_lo      = 8'h0;
    held_company = 16'h0;
    sig_left     = 8'h0;
    ven_left     = 8'h0;
    ven_total    = 8'h0;
    kept_sig     = 8'h0;
    elem_ctr     = 8'h0;
    func_mask    = 5'h0;
    in_page      = 1'b0;
    mask_reg     = 5'h0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rows = '{
      // one-byte page: truncated, no element
      '{8'hff, 1'b1, 1'b1, '{KIND_PAGE_END, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 5'h0a, 8'h0,
                            1'b1, 1'b1}},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
      '{8'h01, 1'b0, 1'b0, '0}, '{8'h80, 1'b0, 1'b0, '0},
      '{8'h55, 1'b0, 1'b0, '0}, '{8'haa, 1'b0, 1'b0, '0},
      '{8'h7f, 1'b0, 1'b0, '0}, '{8'hfe, 1'b0, 1'b0, '0},
      // features word
      '{8'h3c, 1'b0, 1'b0, '0},
      '{8'hc3, 1'b0, 1'b1, '{KIND_FEATURES, 16'hc33c, 16'h0, 8'h0, 8'h0, 8'h0, 5'h0a, 8'h0,
                            1'b0, 1'b1}},
      // location, then two sig models and one vendor model
      '{8'hff, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, '0},
      // config client dropped, light lc kept
      '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
      '{8'h0f, 1'b0, 1'b0, '0}, '{8'h13, 1'b0, 1'b0, '0},
      // vendor pair closing element and page in one transaction
      '{8'hff, 1'b0, 1'b0, '0}, '{8'hff, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b1, 1'b0, '0}
    };
    write_mask(5'h0a);
    foreach (directed_rows[i]) byte_stream.push_back(directed_rows[i]);
    send_stream();
    settle();

    write_mask(5'h1f);
    add_random_pages(45);
    send_stream();
    settle();

    write_mask(5'h00);
    add_random_pages(30);
    send_stream();
    settle();

    // register write in the middle of a page
    add_random_page();
    split = $urandom_range(1, byte_stream.size());
    while (byte_stream.size() > split) tail.push_front(byte_stream.pop_back());
    send_stream();
    settle();
    write_mask(5'($urandom));
    byte_stream = tail;
    add_random_pages(25);
    send_stream();
    settle();

    if (expected_records.size() > 0)
      report_mismatch("records never seen", 16'(expected_records.size()), 16'h0);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== mesh_composition_page0_parser.f =====
design/mcp0_pkg.sv
design/mcp0_parse.sv
design/mcp0_rec_fifo.sv
design/mesh_composition_page0_parser.sv
design/mcp0_chk.sv
tb/mesh_composition_page0_parser_test.sv
